/* hw/rtl/mbq_pkg.sv */
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared types and codes for the filtered mailbox queue: request and
// response payloads, request kinds and status codes.
// ----------------------------------------------------------------------------
package mbq_pkg;

    localparam int ID_W   = 16;
    localparam int BODY_W = 64;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_RECV = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   sender_id;
        logic [BODY_W-1:0] payload;
        logic [ID_W-1:0]   filter_id;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_sender;
        logic [BODY_W-1:0] out_payload;
    } rsp_t;

endpackage

/* hw/rtl/filtered_mailbox_queue.sv */
// ----------------------------------------------------------------------------
// filtered_mailbox_queue
// Bounded message mailbox with selective dequeue by sender.
//
//   channel  valid      stall      payload  dir
//   request  req_valid  req_stall  req      in   (send or receive)
//   response rsp_valid  rsp_stall  rsp      out  (one per request)
//
// A send passes through the EXEC and DONE states before its response is
// registered. During a receive the sequencer reads one entry per cycle
// through the single RAM read port while scanning, then moves one entry per
// cycle after the match. Reset clears the fill count, the sequencer state
// and the response valid; entry contents are not cleared. The response sits
// in an output register, so a stalled response holds only the sequencer's last step.
// ----------------------------------------------------------------------------
module filtered_mailbox_queue #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mbq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mbq_pkg::rsp_t rsp
);

    logic          idle;
    logic          start;
    logic          done;
    logic          out_free;
    mbq_pkg::rsp_t res;

    logic          rsp_valid_reg, rsp_valid_next;
    mbq_pkg::rsp_t rsp_reg, rsp_next;

    assign req_stall = !idle;
    assign start     = req_valid && idle;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    mbq_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (req),
        .out_free (out_free),
        .idle     (idle),
        .done     (done),
        .res      (res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            // drop the response once its transfer is done
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* hw/rtl/mbq_ram.sv */
// ----------------------------------------------------------------------------
// mbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/mbq_ctrl.sv */
// ----------------------------------------------------------------------------
// mbq_ctrl
// Sequencer for the mailbox: appends on send unless full, scans for the
// first matching sender on receive and then moves later entries forward one
// per cycle, all through one RAM port pair and one shared sender compare.
// ----------------------------------------------------------------------------
module mbq_ctrl #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mbq_pkg::req_t cmd,
    input  logic          out_free,
    output logic          idle,
    output logic          done,
    output mbq_pkg::rsp_t res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = mbq_pkg::ID_W + PAYLOAD_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    mbq_pkg::req_t    cmd_reg, cmd_next;
    mbq_pkg::rsp_t    res_reg, res_next;

    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [ENT_W-1:0]           wr_data;
    logic [IDX_W-1:0]           rd_addr;
    logic [ENT_W-1:0]           rd_data;
    logic [mbq_pkg::ID_W-1:0]   rd_sender;
    logic [PAYLOAD_BITS-1:0]    rd_body;
    logic                       match;
    logic [CNT_W-1:0]           ptr_ext;
    logic [CNT_W-1:0]           ptr_p1;
    logic [CNT_W-1:0]           ptr_p2;

    mbq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_sender = rd_data[ENT_W-1 -: mbq_pkg::ID_W];
    assign rd_body   = rd_data[PAYLOAD_BITS-1:0];

    // shared compare: filter of zero takes any sender
    assign match = (cmd_reg.filter_id == '0) || (rd_sender == cmd_reg.filter_id);

    assign ptr_ext = CNT_W'(ptr_reg);
    assign ptr_p1  = ptr_ext + CNT_W'(1);
    assign ptr_p2  = ptr_ext + CNT_W'(2);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data;
        rd_addr    = ptr_reg;
        idle       = 1'b0;
        done       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next = '0;
                if (cmd_reg.kind == mbq_pkg::KIND_SEND)
                begin
                    if (cnt_reg == CNT_W'(DEPTH))
                    begin
                        res_next.status = mbq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = cnt_reg[IDX_W-1:0];
                        wr_data         = {cmd_reg.sender_id,
                                           cmd_reg.payload[PAYLOAD_BITS-1:0]};
                        cnt_next        = cnt_reg + CNT_W'(1);
                        res_next.status = mbq_pkg::ST_OK;
                    end
                    state_next = S_DONE;
                end
                else if (cnt_reg == '0)
                begin
                    res_next.status = mbq_pkg::ST_NOMATCH;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_addr    = '0;
                    ptr_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    res_next.status      = mbq_pkg::ST_OK;
                    res_next.out_sender  = rd_sender;
                    res_next.out_payload = mbq_pkg::BODY_W'(rd_body);
                    if (ptr_p1 < cnt_reg)
                    begin
                        // fetch the next entry to move into the hole
                        rd_addr    = ptr_p1[IDX_W-1:0];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
                else if (ptr_p1 < cnt_reg)
                begin
                    rd_addr  = ptr_p1[IDX_W-1:0];
                    ptr_next = ptr_p1[IDX_W-1:0];
                end
                else
                begin
                    res_next.status = mbq_pkg::ST_NOMATCH;
                    state_next      = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // entry ptr+1 is on the read port: move it down to ptr
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data;
                if (ptr_p2 < cnt_reg)
                begin
                    rd_addr  = ptr_p2[IDX_W-1:0];
                    ptr_next = ptr_p1[IDX_W-1:0];
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold the result until the output register can take it
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
